>>> sv/bclip_pkg.sv
`timescale 1ns / 1ps
// Package for the block-transfer rectangle clipper.
// Item and axis types, register codes, clip check codes and the per-check trim math.
// No dependencies.
package bclip_pkg;

  localparam int COORD_BITS = 16;
  localparam int INT_BITS   = COORD_BITS + 2;
  localparam int NUM_REGS   = 8;
  localparam int IDX_BITS   = $clog2(NUM_REGS);
  localparam int NUM_STAGES = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [INT_BITS-1:0]   int_t;
  typedef logic [IDX_BITS-1:0]          reg_idx_t;
  typedef logic [1:0]                   check_t;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  localparam reg_idx_t REG_DST_MIN_X = 3'd0;
  localparam reg_idx_t REG_DST_MIN_Y = 3'd1;
  localparam reg_idx_t REG_DST_MAX_X = 3'd2;
  localparam reg_idx_t REG_DST_MAX_Y = 3'd3;
  localparam reg_idx_t REG_SRC_MIN_X = 3'd4;
  localparam reg_idx_t REG_SRC_MIN_Y = 3'd5;
  localparam reg_idx_t REG_SRC_MAX_X = 3'd6;
  localparam reg_idx_t REG_SRC_MAX_Y = 3'd7;

  localparam check_t CHK_DST_MIN = 2'd0;
  localparam check_t CHK_DST_MAX = 2'd1;
  localparam check_t CHK_SRC_MIN = 2'd2;
  localparam check_t CHK_SRC_MAX = 2'd3;

  typedef struct packed {
    coord_t dst_x;
    coord_t dst_y;
    coord_t src_min_x;
    coord_t src_min_y;
    coord_t src_max_x;
    coord_t src_max_y;
  } in_item_t;

  typedef struct packed {
    coord_t out_dst_x;
    coord_t out_dst_y;
    coord_t out_src_min_x;
    coord_t out_src_min_y;
    coord_t out_src_max_x;
    coord_t out_src_max_y;
    logic   visible;
  } out_item_t;

  // one axis of an item in flight: corner, source edges, extent
  typedef struct packed {
    int_t p;
    int_t r0;
    int_t r1;
    int_t w;
  } axis_t;

  typedef struct packed {
    coord_t dst_min_x;
    coord_t dst_min_y;
    coord_t dst_max_x;
    coord_t dst_max_y;
    coord_t src_min_x;
    coord_t src_min_y;
    coord_t src_max_x;
    coord_t src_max_y;
  } clip_win_t;

  function automatic int_t sext(input coord_t v);
    int_t r;
    r = {{(INT_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
    return r;
  endfunction

  function automatic axis_t mk_axis(input coord_t p, input coord_t r0, input coord_t r1);
    axis_t a;
    a.p  = sext(p);
    a.r0 = sext(r0);
    a.r1 = sext(r1);
    a.w  = a.r1 - a.r0;
    return a;
  endfunction

  function automatic axis_t trim(input axis_t a, input check_t chk, input coord_t lim);
    int_t  l;
    int_t  s;
    int_t  t;
    axis_t r;
    l = sext(lim);
    s = a.p + a.w;
    t = '0;
    r = a;
    case (chk)
      CHK_DST_MIN: begin
        if (a.p < l) begin
          t    = l - a.p;
          r.p  = a.p + t;
          r.r0 = a.r0 + t;
          r.w  = a.w - t;
        end
      end
      CHK_DST_MAX: begin
        if (s > l) begin
          t    = s - l;
          r.r1 = a.r1 - t;
          r.w  = a.w - t;
        end
      end
      CHK_SRC_MIN: begin
        if (a.r0 < l) begin
          t    = l - a.r0;
          r.p  = a.p + t;
          r.r0 = a.r0 + t;
          r.w  = a.w - t;
        end
      end
      CHK_SRC_MAX: begin
        if (a.r1 > l) begin
          t    = a.r1 - l;
          r.r1 = a.r1 - t;
          r.w  = a.w - t;
        end
      end
      default: r = a;
    endcase
    return r;
  endfunction

  function automatic coord_t sat(input int_t v);
    coord_t r;
    if ((&v[INT_BITS-1:COORD_BITS-1]) || !(|v[INT_BITS-1:COORD_BITS-1])) begin
      r = v[COORD_BITS-1:0];
    end else if (v[INT_BITS-1]) begin
      r = COORD_MIN;
    end else begin
      r = COORD_MAX;
    end
    return r;
  endfunction

endpackage

>>> sv/bclip_cfg.sv
`timescale 1ns / 1ps
// Clip window register file, written through the plain write port.
// Depends on bclip_pkg.
module bclip_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  bclip_pkg::reg_idx_t cfg_index,
  input  bclip_pkg::coord_t   cfg_data,
  output bclip_pkg::clip_win_t win
);

  always_ff @(posedge clk) begin
    if (rst) begin
      win.dst_min_x <= bclip_pkg::COORD_MIN;
      win.dst_min_y <= bclip_pkg::COORD_MIN;
      win.dst_max_x <= bclip_pkg::COORD_MAX;
      win.dst_max_y <= bclip_pkg::COORD_MAX;
      win.src_min_x <= bclip_pkg::COORD_MIN;
      win.src_min_y <= bclip_pkg::COORD_MIN;
      win.src_max_x <= bclip_pkg::COORD_MAX;
      win.src_max_y <= bclip_pkg::COORD_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        bclip_pkg::REG_DST_MIN_X: win.dst_min_x <= cfg_data;
        bclip_pkg::REG_DST_MIN_Y: win.dst_min_y <= cfg_data;
        bclip_pkg::REG_DST_MAX_X: win.dst_max_x <= cfg_data;
        bclip_pkg::REG_DST_MAX_Y: win.dst_max_y <= cfg_data;
        bclip_pkg::REG_SRC_MIN_X: win.src_min_x <= cfg_data;
        bclip_pkg::REG_SRC_MIN_Y: win.src_min_y <= cfg_data;
        bclip_pkg::REG_SRC_MAX_X: win.src_max_x <= cfg_data;
        bclip_pkg::REG_SRC_MAX_Y: win.src_max_y <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/bclip_stage.sv
`timescale 1ns / 1ps
// One pipeline stage: a single clip check applied to both axes, registered.
// Depends on bclip_pkg.
module bclip_stage (
  input  logic               clk,
  input  logic               rst,
  input  bclip_pkg::check_t  chk,
  input  bclip_pkg::coord_t  lim_x,
  input  bclip_pkg::coord_t  lim_y,
  input  logic               in_valid,
  input  bclip_pkg::axis_t   in_x,
  input  bclip_pkg::axis_t   in_y,
  output logic               out_valid,
  output bclip_pkg::axis_t   out_x,
  output bclip_pkg::axis_t   out_y
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_x <= bclip_pkg::trim(in_x, chk, lim_x);
    out_y <= bclip_pkg::trim(in_y, chk, lim_y);
  end

endmodule

>>> sv/bclip_out.sv
`timescale 1ns / 1ps
// Output stage: saturates coordinates, forms the visible flag, drives the strobe.
// Depends on bclip_pkg.
module bclip_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  bclip_pkg::axis_t     in_x,
  input  bclip_pkg::axis_t     in_y,
  output logic                 done,
  output bclip_pkg::out_item_t result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.out_dst_x     <= bclip_pkg::sat(in_x.p);
    result.out_dst_y     <= bclip_pkg::sat(in_y.p);
    result.out_src_min_x <= bclip_pkg::sat(in_x.r0);
    result.out_src_min_y <= bclip_pkg::sat(in_y.r0);
    result.out_src_max_x <= bclip_pkg::sat(in_x.r1);
    result.out_src_max_y <= bclip_pkg::sat(in_y.r1);
    result.visible       <= (in_x.w > 0) && (in_y.w > 0);
  end

endmodule

>>> sv/blit_rectangle_clipper.sv
`timescale 1ns / 1ps
// Block-transfer rectangle clipper. An item is taken at every clock edge with start high
// and busy low; busy is set during reset and cleared at the first clock edge that samples
// reset low. Each item comes out on result with done high for one cycle; the result
// cannot be held off and must be captured then. The path is the input register, four
// check stages (destination min, destination max, source min, source max, both axes in
// parallel) and the saturating output register; while busy is low one item per cycle is
// sustained. Depends on bclip_pkg, bclip_cfg, bclip_stage, bclip_out.
module blit_rectangle_clipper (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  bclip_pkg::in_item_t  req,
  output logic                 done,
  output bclip_pkg::out_item_t result,
  input  logic                 cfg_we,
  input  bclip_pkg::reg_idx_t  cfg_index,
  input  bclip_pkg::coord_t    cfg_data
);

  bclip_pkg::clip_win_t win;
  logic                 accept;
  logic                 vld [bclip_pkg::NUM_STAGES+1];
  bclip_pkg::axis_t     ax_x [bclip_pkg::NUM_STAGES+1];
  bclip_pkg::axis_t     ax_y [bclip_pkg::NUM_STAGES+1];
  bclip_pkg::check_t    chk [bclip_pkg::NUM_STAGES];
  bclip_pkg::coord_t    lim_x [bclip_pkg::NUM_STAGES];
  bclip_pkg::coord_t    lim_y [bclip_pkg::NUM_STAGES];

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  bclip_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win       (win)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    ax_x[0] <= bclip_pkg::mk_axis(req.dst_x, req.src_min_x, req.src_max_x);
    ax_y[0] <= bclip_pkg::mk_axis(req.dst_y, req.src_min_y, req.src_max_y);
  end

  assign chk[0]   = bclip_pkg::CHK_DST_MIN;
  assign lim_x[0] = win.dst_min_x;
  assign lim_y[0] = win.dst_min_y;
  assign chk[1]   = bclip_pkg::CHK_DST_MAX;
  assign lim_x[1] = win.dst_max_x;
  assign lim_y[1] = win.dst_max_y;
  assign chk[2]   = bclip_pkg::CHK_SRC_MIN;
  assign lim_x[2] = win.src_min_x;
  assign lim_y[2] = win.src_min_y;
  assign chk[3]   = bclip_pkg::CHK_SRC_MAX;
  assign lim_x[3] = win.src_max_x;
  assign lim_y[3] = win.src_max_y;

  for (genvar i = 0; i < bclip_pkg::NUM_STAGES; i++) begin : g_stg
    bclip_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .chk       (chk[i]),
      .lim_x     (lim_x[i]),
      .lim_y     (lim_y[i]),
      .in_valid  (vld[i]),
      .in_x      (ax_x[i]),
      .in_y      (ax_y[i]),
      .out_valid (vld[i+1]),
      .out_x     (ax_x[i+1]),
      .out_y     (ax_y[i+1])
    );
  end

  bclip_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[bclip_pkg::NUM_STAGES]),
    .in_x     (ax_x[bclip_pkg::NUM_STAGES]),
    .in_y     (ax_y[bclip_pkg::NUM_STAGES]),
    .done     (done),
    .result   (result)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 done)
    else $error("accepted item did not complete in six cycles");

  a_no_done_after_reset: assert property (@(posedge clk)
    done |-> !$past(rst))
    else $error("result strobe right after reset");

  a_busy_only_reset: assert property (@(posedge clk)
    busy |-> $past(rst))
    else $error("busy raised outside reset");

endmodule
